FILE: rtl/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg: shared types and constants of the key/value list tokenizer
// Character codes, position widths, scan phase and the scan result record.
// ----------------------------------------------------------------------------
package kvlt_pkg;

  // Longest string before offsets saturate
  localparam int unsigned MaxStringLen = 4096;
  // Positions run from 0 up to and including MaxStringLen
  localparam int unsigned PosW = $clog2(MaxStringLen + 1);
  // Width of the offset and length result fields
  localparam int unsigned FieldW = 13;

  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [1:0] {
    PH_PRE_KEY = 2'd0,
    PH_KEY     = 2'd1,
    PH_PRE_VAL = 2'd2,
    PH_VAL     = 2'd3
  } scan_phase_e;

  typedef struct packed {
    logic              emit;
    logic              pair_valid;
    logic [FieldW-1:0] key_offset;
    logic [FieldW-1:0] key_length;
    logic [FieldW-1:0] value_offset;
    logic [FieldW-1:0] value_length;
    logic              string_done;
    logic              length_overflow;
  } scan_result_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic [PosW-1:0] next_pos(logic [PosW-1:0] p);
    return (p >= PosW'(MaxStringLen)) ? PosW'(MaxStringLen) : p + PosW'(1);
  endfunction

endpackage

FILE: rtl/kvlt_scan.sv
// ----------------------------------------------------------------------------
// kvlt_scan: per-byte scan state and pair detection
// Holds the parse state of the current string and works out, for one byte,
// the next state and the result (if any) that the byte causes.
// ----------------------------------------------------------------------------
module kvlt_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  final_byte_i,
  output kvlt_pkg::scan_result_t result_o
);

  typedef struct packed {
    kvlt_pkg::scan_phase_e       phase;
    logic [kvlt_pkg::PosW-1:0]   byte_pos;
    logic [kvlt_pkg::PosW-1:0]   key_begin;
    logic [kvlt_pkg::PosW-1:0]   key_finish;
    logic [kvlt_pkg::PosW-1:0]   val_begin;
    logic [kvlt_pkg::PosW-1:0]   val_finish;
    logic                        overflow;
    logic                        term;
  } scan_state_t;

  localparam scan_state_t ClearState = '{
    phase:      kvlt_pkg::PH_PRE_KEY,
    byte_pos:   '0,
    key_begin:  '0,
    key_finish: '0,
    val_begin:  '0,
    val_finish: '0,
    overflow:   1'b0,
    term:       1'b0
  };

  scan_state_t state_q, state_d;
  scan_state_t scan_upd;
  logic        pair;
  logic        close;

  // Next state: advance the scan by one byte, clear it when the string closes
  always_comb begin
    logic [kvlt_pkg::PosW-1:0] pos;
    logic [kvlt_pkg::PosW-1:0] endpos;
    logic                      blank;
    logic [kvlt_pkg::PosW-1:0] pos_nxt;

    scan_upd = state_q;
    pos      = state_q.byte_pos;
    endpos   = pos;
    pair     = 1'b0;
    close    = 1'b0;
    blank    = kvlt_pkg::is_blank(text_byte_i);
    pos_nxt  = '0;

    if (state_q.term) begin
      // drop bytes after a zero byte; a final byte rearms
      if (final_byte_i) begin
        scan_upd = ClearState;
      end
    end else if (text_byte_i == kvlt_pkg::ChNul) begin
      close = 1'b1;
    end else begin
      if (pos >= kvlt_pkg::PosW'(kvlt_pkg::MaxStringLen)) begin
        scan_upd.overflow = 1'b1;
        pos = kvlt_pkg::PosW'(kvlt_pkg::MaxStringLen);
      end
      pos_nxt = kvlt_pkg::next_pos(pos);
      case (state_q.phase)
        kvlt_pkg::PH_PRE_KEY: begin
          if (text_byte_i == kvlt_pkg::ChComma || blank) begin
            scan_upd.phase = kvlt_pkg::PH_PRE_KEY;
          end else if (text_byte_i == kvlt_pkg::ChEquals) begin
            scan_upd.key_begin  = pos;
            scan_upd.key_finish = pos;
            scan_upd.phase      = kvlt_pkg::PH_PRE_VAL;
          end else begin
            scan_upd.key_begin  = pos;
            scan_upd.key_finish = pos_nxt;
            scan_upd.phase      = kvlt_pkg::PH_KEY;
          end
        end
        kvlt_pkg::PH_KEY: begin
          if (text_byte_i == kvlt_pkg::ChEquals) begin
            scan_upd.phase = kvlt_pkg::PH_PRE_VAL;
          end else if (text_byte_i == kvlt_pkg::ChComma) begin
            scan_upd.phase = kvlt_pkg::PH_PRE_KEY;
          end else if (!blank) begin
            scan_upd.key_finish = pos_nxt;
          end
        end
        kvlt_pkg::PH_PRE_VAL: begin
          if (text_byte_i == kvlt_pkg::ChComma) begin
            scan_upd.val_begin  = pos;
            scan_upd.val_finish = pos;
            scan_upd.phase      = kvlt_pkg::PH_PRE_KEY;
            pair                = 1'b1;
          end else if (!blank) begin
            scan_upd.val_begin  = pos;
            scan_upd.val_finish = pos_nxt;
            scan_upd.phase      = kvlt_pkg::PH_VAL;
          end
        end
        kvlt_pkg::PH_VAL: begin
          if (text_byte_i == kvlt_pkg::ChComma) begin
            scan_upd.phase = kvlt_pkg::PH_PRE_KEY;
            pair           = 1'b1;
          end else if (!blank) begin
            scan_upd.val_finish = pos_nxt;
          end
        end
        default: begin
          scan_upd.phase = kvlt_pkg::PH_PRE_KEY;
        end
      endcase
      scan_upd.byte_pos = pos_nxt;
      endpos            = pos_nxt;
      close             = final_byte_i;
    end

    // close out a pending pair when the string ends
    if (close && !pair) begin
      if (scan_upd.phase == kvlt_pkg::PH_PRE_VAL) begin
        scan_upd.val_begin  = endpos;
        scan_upd.val_finish = endpos;
        pair                = 1'b1;
      end else if (scan_upd.phase == kvlt_pkg::PH_VAL) begin
        pair = 1'b1;
      end
    end

    state_d = scan_upd;
    if (close) begin
      state_d      = ClearState;
      state_d.term = (text_byte_i == kvlt_pkg::ChNul) && !final_byte_i;
    end
  end

  // Outputs: the result that the byte causes
  always_comb begin
    result_o                 = '0;
    result_o.emit            = close || pair;
    result_o.pair_valid      = pair;
    result_o.string_done     = close;
    result_o.length_overflow = scan_upd.overflow;
    if (pair) begin
      result_o.key_offset   = kvlt_pkg::FieldW'(scan_upd.key_begin);
      result_o.key_length   = kvlt_pkg::FieldW'(scan_upd.key_finish - scan_upd.key_begin);
      result_o.value_offset = kvlt_pkg::FieldW'(scan_upd.val_begin);
      result_o.value_length = kvlt_pkg::FieldW'(scan_upd.val_finish - scan_upd.val_begin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ClearState;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/key_value_list_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// key_value_list_tokenizer_unit: comma-separated key=value list tokenizer
// Splits a byte stream into key=value pairs and reports offsets and lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one text byte per item,
//   with final_byte_i marking the last byte of a string. A zero byte also
//   ends the string; bytes after it are dropped up to the next final byte.
//   Output channel (out_valid_o / out_ready_i) carries a result for each
//   completed pair and for each string end (string_done_o); a pair that
//   ends with the string shares that closing result. An accepted byte
//   passes the input register, then scan logic, then the result register.
//   Throughput: one byte per cycle while the receiver keeps up; the scan
//   state is updated at each step, so nothing limits the rate but the
//   output handshake.
//   Stall: the input register and the result register each hold one item,
//   so with the receiver stalled up to two items are held before in_ready_o
//   drops; the scan step only advances when the result register can take.
//   Reset: rst_ni clears the scan state to the start of a new string and
//   empties both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_value_list_tokenizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        final_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        pair_valid_o,
  output logic [kvlt_pkg::FieldW-1:0] key_offset_o,
  output logic [kvlt_pkg::FieldW-1:0] key_length_o,
  output logic [kvlt_pkg::FieldW-1:0] value_offset_o,
  output logic [kvlt_pkg::FieldW-1:0] value_length_o,
  output logic                        string_done_o,
  output logic                        length_overflow_o
);

  // Input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       final_q;

  // Result register
  logic                   out_vld_q;
  kvlt_pkg::scan_result_t res_q;
  kvlt_pkg::scan_result_t scan_res;

  logic step;

  // Advance the scan when the result register is free or being emptied
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= text_byte_i;
      final_q <= final_byte_i;
    end
  end

  kvlt_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .text_byte_i  (byte_q),
    .final_byte_i (final_q),
    .result_o     (scan_res)
  );

  // Load a new result, or drop the old one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= scan_res.emit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && scan_res.emit) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign pair_valid_o      = res_q.pair_valid;
  assign key_offset_o      = res_q.key_offset;
  assign key_length_o      = res_q.key_length;
  assign value_offset_o    = res_q.value_offset;
  assign value_length_o    = res_q.value_length;
  assign string_done_o     = res_q.string_done;
  assign length_overflow_o = res_q.length_overflow;

`ifndef NO_ASSERTIONS
  // A result without a pair carries zero offsets and lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |->
      key_offset_o == '0 && key_length_o == '0 &&
      value_offset_o == '0 && value_length_o == '0)
    else $error("kvlt: non-pair result with nonzero fields");

  // An empty input register always takes a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("kvlt: input stalled while empty");

  // A held result is not overwritten while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !step)
    else $error("kvlt: scan advanced over a stalled result");

  // Key extent never passes the saturation point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_valid_o |->
      ({1'b0, key_offset_o} + {1'b0, key_length_o}) <=
        (kvlt_pkg::FieldW + 1)'(kvlt_pkg::MaxStringLen))
    else $error("kvlt: key extent beyond maximum length");
`endif

endmodule
